// ===== src/resource_pool_with_waiter_fifo_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the resource pool
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RESOURCE_POOL_WITH_WAITER_FIFO_ASSERT_SVH
`define RESOURCE_POOL_WITH_WAITER_FIFO_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define RPW_ASSERT_IMPLIES(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("resource pool assertion failed");

// The condition holds in the cycle after the trigger.
`define RPW_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("resource pool assertion failed");

`endif

// ===== src/rpw_pkg.sv =====
// ----------------------------------------------------------------------------
// Resource pool package
// Types, codes and constants shared by the pool front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package rpw_pkg;

	localparam int SHARD_COUNT     = 16;
	localparam int SHARD_BITS      = 4;
	localparam int SLOT_COUNT      = SHARD_COUNT * SHARD_BITS;
	localparam int SLOT_IDX_W      = 6;
	localparam int SHARD_W         = 4;
	localparam int BIT_W           = 2;
	localparam int DEF_QUEUE_DEPTH = 256;
	localparam int MOD_STEPS       = 4;
	localparam int MOD_CYCLES      = 8;

	localparam logic [6:0]  POOL_RESET  = 7'd64;
	localparam logic [15:0] STALE_RESET = 16'd1000;

	localparam logic [2:0] OP_REGISTER = 3'd0;
	localparam logic [2:0] OP_CHECKOUT = 3'd1;
	localparam logic [2:0] OP_CHECKIN  = 3'd2;
	localparam logic [2:0] OP_CANCEL   = 3'd3;
	localparam logic [2:0] OP_RECLAIM  = 3'd4;

	localparam logic [2:0] OUT_GRANTED = 3'd0;
	localparam logic [2:0] OUT_QUEUED  = 3'd1;
	localparam logic [2:0] OUT_FULL    = 3'd2;
	localparam logic [2:0] OUT_DONE    = 3'd3;
	localparam logic [2:0] OUT_WAITER  = 3'd4;
	localparam logic [2:0] OUT_IDLED   = 3'd5;

	localparam logic [1:0] COND_UNREG = 2'd0;
	localparam logic [1:0] COND_IDLE  = 2'd1;
	localparam logic [1:0] COND_TAKEN = 2'd2;

	localparam logic REG_POOL_SLOTS = 1'b0;
	localparam logic REG_STALE      = 1'b1;

	typedef struct packed {
		logic [2:0]  operation;
		logic [6:0]  slot_number;
		logic [15:0] connection_tag;
		logic [15:0] requester_tag;
		logic [10:0] scheduler_number;
		logic [31:0] ticket;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  outcome;
		logic [15:0] granted_to;
		logic [15:0] granted_connection;
		logic [6:0]  granted_slot;
		logic [31:0] queue_ticket;
		logic        last;
	} out_item_t;

	typedef enum logic [2:0] {
		K_REGISTER,
		K_CHECKOUT,
		K_CHECKIN,
		K_CANCEL,
		K_RECLAIM,
		K_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic                  slot_ok;
		logic [SLOT_IDX_W-1:0] slot_idx;
		logic [15:0]           conn;
		logic [15:0]           req;
		logic [31:0]           ticket;
		logic [31:0]           now;
		logic [SHARD_W-1:0]    pshard;
		logic [BIT_W-1:0]      pbit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} cmdq_status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MOD,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_PASS,
		B_PASS_CHK,
		B_SEARCH,
		B_GRANT,
		B_QUEUE,
		B_CANCEL_RD,
		B_CANCEL,
		B_RREAD,
		B_RCHK,
		B_RPUSH,
		B_EMIT
	} back_state_t;

	function automatic out_item_t mk_result(logic [2:0] outcome, logic [15:0] to,
			logic [15:0] conn, logic [6:0] slot, logic [31:0] tkt, logic last);
		out_item_t r;
		r.outcome            = outcome;
		r.granted_to         = to;
		r.granted_connection = conn;
		r.granted_slot       = slot;
		r.queue_ticket       = tkt;
		r.last               = last;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/resource_pool_with_waiter_fifo.sv =====
// ----------------------------------------------------------------------------
// Resource pool with waiter queue
// Slot pool allocator with a bounded ring of waiting requesters.
// ----------------------------------------------------------------------------
// Requests enter on the in channel (valid/ready) as one in_item transfer each:
// register, checkout, checkin, cancel or reclaim. Results leave on the out
// channel; every request yields one or more transfers and the final one has
// last set. Reclaim yields one transfer per freed slot, or a single done.
// The front end holds one request: for a checkout it forms the remainder of
// the scheduler number minus one by the pool size, four bits a cycle; other
// requests go straight on to the queue. In the back end a checkout walks the
// shards in the shard search, handing on a slot skips cancelled waiters and
// reclaim scans each slot and passes on every stale one. A two-entry command
// queue lets the front end take the next request while the back end still
// works. When the receiver stalls, the output register holds its transfer
// and the back end waits; the front end keeps filling the queue until it is
// full. Reset clears all slots to unregistered and empties the ring at once;
// no clearing pass is needed. Configuration registers sit on the APB port at
// byte addresses 0 (pool size) and 4 (stale limit).
// ----------------------------------------------------------------------------
`default_nettype none

module resource_pool_with_waiter_fifo import rpw_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_item
);

	logic [6:0]   pool_q;
	logic [15:0]  stale_q;
	logic [6:0]   psize;
	logic         cfg_wr;
	logic         cmd_push, cmd_pop;
	cmd_t         cmd, head;
	cmdq_status_t q_status;
	logic         slotless_out;

	// Register writes complete in the access phase; the port never waits.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q  <= POOL_RESET;
			stale_q <= STALE_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_POOL_SLOTS: pool_q  <= pwdata[6:0];
				REG_STALE:      stale_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_POOL_SLOTS: prdata = {25'd0, pool_q};
			REG_STALE:      prdata = {16'd0, stale_q};
			default:        prdata = '0;
		endcase
	end

	// A zero pool size behaves as one slot, oversize values as the full pool.
	always_comb begin
		if (pool_q == 7'd0)                    psize = 7'd1;
		else if (pool_q > 7'(SLOT_COUNT))      psize = 7'(SLOT_COUNT);
		else                                   psize = pool_q;
	end

	rpw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.psize    (psize),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.cmd_push (cmd_push),
		.cmd      (cmd),
		.q_status (q_status)
	);

	rpw_cmd_fifo u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd),
		.pop      (cmd_pop),
		.head     (head),
		.status   (q_status)
	);

	rpw_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.psize     (psize),
		.stale     (stale_q),
		.q_status  (q_status),
		.head      (head),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// A result that hands out no slot: queued, full or done.
	assign slotless_out = out_valid && (out_item.outcome == OUT_QUEUED ||
		out_item.outcome == OUT_FULL || out_item.outcome == OUT_DONE);

	`include "resource_pool_with_waiter_fifo_assert.svh"

	// The front end never pushes into a full command queue.
	`RPW_ASSERT_IMPLIES(a_push_not_full, cmd_push, !q_status.full)
	// Results that hand out no slot carry slot number zero.
	`RPW_ASSERT_IMPLIES(a_slotless_result, slotless_out, out_item.granted_slot == 7'd0)
	// A queued answer is always the only transfer of its request.
	`RPW_ASSERT_IMPLIES(a_queued_last, out_valid && out_item.outcome == OUT_QUEUED, out_item.last)
	// The front end holds one request at a time.
	`RPW_ASSERT_NEXT(a_front_single, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

// ===== src/rpw_front.sv =====
// ----------------------------------------------------------------------------
// Resource pool front end
// Takes one request, classifies it and works out the preferred shard and bit.
// ----------------------------------------------------------------------------
`default_nettype none

module rpw_front import rpw_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [6:0]   psize,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire in_item_t     in_item,
	output logic              cmd_push,
	output cmd_t              cmd,
	input  wire cmdq_status_t q_status
);

	front_state_t state_q, state_d;
	in_item_t     item_q;
	logic [31:0]  div_q, div_d;
	logic [6:0]   rem_q, rem_d;
	logic [2:0]   cnt_q;
	logic         accept;

	assign accept = in_valid && in_ready;

	// Remainder by the pool size, four dividend bits a cycle.
	always_comb begin
		logic [7:0] t;
		rem_d = rem_q;
		div_d = div_q;
		t     = '0;
		for (int j = 0; j < MOD_STEPS; j++) begin
			t     = {rem_d, div_d[31]};
			div_d = {div_d[30:0], 1'b0};
			if (t >= {1'b0, psize}) begin
				t = t - {1'b0, psize};
			end
			rem_d = t[6:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = (in_item.operation == OP_CHECKOUT) ? F_MOD : F_PUSH;
				end
			end
			F_MOD: begin
				if (cnt_q == 3'(MOD_CYCLES - 1)) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_status.full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == F_IDLE);
		cmd_push = (state_q == F_PUSH) && !q_status.full;
		unique case (item_q.operation)
			OP_REGISTER: cmd.kind = K_REGISTER;
			OP_CHECKOUT: cmd.kind = K_CHECKOUT;
			OP_CHECKIN:  cmd.kind = K_CHECKIN;
			OP_CANCEL:   cmd.kind = K_CANCEL;
			OP_RECLAIM:  cmd.kind = K_RECLAIM;
			default:     cmd.kind = K_NOP;
		endcase
		cmd.slot_ok  = (item_q.slot_number != 7'd0) && (item_q.slot_number <= psize);
		cmd.slot_idx = 6'(item_q.slot_number - 7'd1);
		cmd.conn     = item_q.connection_tag;
		cmd.req      = item_q.requester_tag;
		cmd.ticket   = item_q.ticket;
		cmd.now      = item_q.now_ms;
		cmd.pshard   = rem_q[3:0];
		cmd.pbit     = rem_q[5:4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == F_MOD) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
			div_q  <= {21'd0, in_item.scheduler_number} - 32'd1;
			rem_q  <= '0;
		end else if (state_q == F_MOD) begin
			div_q <= div_d;
			rem_q <= rem_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/rpw_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Resource pool command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rpw_cmd_fifo import rpw_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire cmd_t  push_cmd,
	input  wire logic  pop,
	output cmd_t       head,
	output cmdq_status_t status
);

	cmd_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign head         = mem_q[rd_q];
	assign status.full  = (cnt_q == 2'd2);
	assign status.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== src/rpw_back.sv =====
// ----------------------------------------------------------------------------
// Resource pool back end
// Carries out commands on the slot state and the waiter ring, one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module rpw_back import rpw_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [6:0]   psize,
	input  wire logic [15:0]  stale,
	input  wire cmdq_status_t q_status,
	input  wire cmd_t         head,
	output logic              cmd_pop,
	output logic              out_valid,
	input  wire logic         out_ready,
	output out_item_t         out_item
);

	localparam int CELL_W = $clog2(QUEUE_DEPTH);

	back_state_t state_q, state_d;
	cmd_t        cur_q;
	logic [SLOT_IDX_W-1:0] idx_q;
	logic [SHARD_W-1:0]    s_q;
	logic [6:0]  scan_q;
	logic [31:0] enq_q, deq_q;
	logic [1:0]  cond_q [SLOT_COUNT];
	out_item_t   res_q, pend_q, out_q, res_d, push_data;
	logic        pend_v_q, out_valid_q;

	logic [15:0] conn_mem [SLOT_COUNT];
	logic [31:0] time_mem [SLOT_COUNT];
	logic [15:0] tag_mem  [QUEUE_DEPTH];
	logic        cxl_mem  [QUEUE_DEPTH];
	logic [15:0] conn_rd_q, tag_rd_q;
	logic [31:0] time_rd_q;
	logic        cxl_rd_q;

	logic pop, out_free, ring_empty, ring_full, reclaiming, last_flag;
	logic cancel_hit, stale_hit, res_ld, push_en, advance_rpush;
	logic [CELL_W-1:0] deq_cell, enq_cell, tkt_cell, tag_raddr;
	logic [SLOT_IDX_W-1:0] conn_raddr, cond_widx;
	logic [1:0]  cond_wdata;
	logic        cond_we, conn_we, time_we, ring_we, cxl_we, cxl_wdata;
	logic [CELL_W-1:0] cxl_waddr;
	logic [6:0]  slot_no;

	// Shard search signals.
	logic [SHARD_W-1:0] shard;
	logic [3:0]         elig, pref;
	logic [BIT_W-1:0]   pick;
	logic               found;
	logic [SLOT_IDX_W-1:0] found_idx;

	assign pop        = (state_q == B_IDLE) && !q_status.empty;
	assign cmd_pop    = pop;
	assign out_free   = !out_valid_q || out_ready;
	assign ring_empty = (deq_q == enq_q);
	assign ring_full  = ((enq_q - deq_q) >= 32'(QUEUE_DEPTH));
	assign deq_cell   = deq_q[CELL_W-1:0];
	assign enq_cell   = enq_q[CELL_W-1:0];
	assign tkt_cell   = cur_q.ticket[CELL_W-1:0];
	assign reclaiming = (cur_q.kind == K_RECLAIM);
	assign last_flag  = !reclaiming;
	assign slot_no    = {1'b0, idx_q} + 7'd1;
	assign cancel_hit = ((cur_q.ticket - deq_q) < (enq_q - deq_q)) && (tag_rd_q == cur_q.req);
	assign stale_hit  = (cond_q[scan_q[5:0]] == COND_TAKEN) &&
		((cur_q.now - time_rd_q) > {16'd0, stale});
	assign advance_rpush = (state_q == B_RPUSH) && (!pend_v_q || out_free);

	always_comb begin
		logic [SLOT_IDX_W-1:0] sidx;
		shard = cur_q.pshard + s_q;
		elig  = '0;
		pref  = '0;
		pick  = '0;
		sidx  = '0;
		for (int b = 0; b < SHARD_BITS; b++) begin
			sidx    = {2'(b), shard};
			elig[b] = (cond_q[sidx] == COND_IDLE) && ({1'b0, sidx} < psize);
			pref[b] = elig[b] && (2'(b) >= cur_q.pbit) && (s_q == '0);
		end
		for (int b = SHARD_BITS - 1; b >= 0; b--) begin
			if (elig[b]) pick = 2'(b);
		end
		if (|pref) begin
			for (int b = SHARD_BITS - 1; b >= 0; b--) begin
				if (pref[b]) pick = 2'(b);
			end
		end
		found     = |elig;
		found_idx = {pick, shard};
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_status.empty) begin
					unique case (head.kind)
						K_REGISTER: state_d = head.slot_ok ? B_PASS : B_EMIT;
						K_CHECKIN:  state_d = (head.slot_ok &&
							cond_q[head.slot_idx] != COND_UNREG) ? B_PASS : B_EMIT;
						K_CHECKOUT: state_d = B_SEARCH;
						K_CANCEL:   state_d = B_CANCEL_RD;
						K_RECLAIM:  state_d = B_RREAD;
						default:    state_d = B_EMIT;
					endcase
				end
			end
			B_PASS: begin
				if (ring_empty) state_d = reclaiming ? B_RPUSH : B_EMIT;
				else            state_d = B_PASS_CHK;
			end
			B_PASS_CHK: begin
				if (cxl_rd_q) state_d = B_PASS;
				else          state_d = reclaiming ? B_RPUSH : B_EMIT;
			end
			B_SEARCH: begin
				if (found)                               state_d = B_GRANT;
				else if (s_q == SHARD_W'(SHARD_COUNT-1)) state_d = B_QUEUE;
			end
			B_GRANT:     state_d = B_EMIT;
			B_QUEUE:     state_d = B_EMIT;
			B_CANCEL_RD: state_d = B_CANCEL;
			B_CANCEL:    state_d = B_EMIT;
			B_RREAD:     state_d = (scan_q == psize) ? B_EMIT : B_RCHK;
			B_RCHK:      state_d = stale_hit ? B_PASS : B_RREAD;
			B_RPUSH: begin
				if (!pend_v_q || out_free) state_d = B_RREAD;
			end
			B_EMIT: begin
				if (out_free) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Strobes and result selection.
	always_comb begin
		res_ld     = 1'b0;
		res_d      = mk_result(OUT_DONE, '0, '0, '0, '0, 1'b1);
		conn_we    = pop && (head.kind == K_REGISTER) && head.slot_ok;
		time_we    = 1'b0;
		cond_we    = 1'b0;
		cond_wdata = COND_IDLE;
		cond_widx  = idx_q;
		ring_we    = 1'b0;
		cxl_we     = 1'b0;
		cxl_wdata  = 1'b0;
		cxl_waddr  = enq_cell;
		push_en    = 1'b0;
		push_data  = res_q;
		conn_raddr = (state_q == B_SEARCH) ? found_idx : idx_q;
		tag_raddr  = (state_q == B_CANCEL_RD) ? tkt_cell : deq_cell;
		unique case (state_q)
			B_IDLE: res_ld = pop;
			B_PASS: begin
				if (ring_empty) begin
					res_ld  = 1'b1;
					res_d   = mk_result(OUT_IDLED, '0, '0, slot_no, '0, last_flag);
					cond_we = 1'b1;
				end
			end
			B_PASS_CHK: begin
				if (!cxl_rd_q) begin
					res_ld     = 1'b1;
					res_d      = mk_result(OUT_WAITER, tag_rd_q, conn_rd_q, slot_no, '0,
						last_flag);
					cond_we    = 1'b1;
					cond_wdata = COND_TAKEN;
					time_we    = 1'b1;
				end
			end
			B_GRANT: begin
				res_ld     = 1'b1;
				res_d      = mk_result(OUT_GRANTED, cur_q.req, conn_rd_q, slot_no, '0, 1'b1);
				cond_we    = 1'b1;
				cond_wdata = COND_TAKEN;
				time_we    = 1'b1;
			end
			B_QUEUE: begin
				res_ld = 1'b1;
				if (ring_full) begin
					res_d = mk_result(OUT_FULL, '0, '0, '0, '0, 1'b1);
				end else begin
					res_d   = mk_result(OUT_QUEUED, '0, '0, '0, enq_q, 1'b1);
					ring_we = 1'b1;
					cxl_we  = 1'b1;
				end
			end
			B_CANCEL: begin
				res_ld    = 1'b1;
				cxl_we    = cancel_hit;
				cxl_wdata = 1'b1;
				cxl_waddr = tkt_cell;
			end
			B_RREAD: begin
				if (scan_q == psize) begin
					res_ld = 1'b1;
					if (pend_v_q) begin
						res_d      = pend_q;
						res_d.last = 1'b1;
					end
				end
			end
			B_RPUSH: begin
				push_en   = pend_v_q && out_free;
				push_data = pend_q;
			end
			B_EMIT: push_en = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			s_q         <= '0;
			scan_q      <= '0;
			enq_q       <= '0;
			deq_q       <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				cond_q[i] <= COND_UNREG;
			end
		end else begin
			state_q <= state_d;
			if (pop) begin
				s_q      <= '0;
				scan_q   <= '0;
				pend_v_q <= 1'b0;
			end
			if (state_q == B_SEARCH && !found) s_q <= s_q + SHARD_W'(1);
			if ((state_q == B_RCHK && !stale_hit) || advance_rpush) scan_q <= scan_q + 7'd1;
			if (advance_rpush) pend_v_q <= 1'b1;
			if (state_q == B_PASS && !ring_empty) deq_q <= deq_q + 32'd1;
			if (ring_we) enq_q <= enq_q + 32'd1;
			if (cond_we) cond_q[cond_widx] <= cond_wdata;
			if (push_en)        out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (pop)                                idx_q <= head.slot_idx;
		else if (state_q == B_SEARCH && found)  idx_q <= found_idx;
		else if (state_q == B_RCHK && stale_hit) idx_q <= scan_q[5:0];
		if (res_ld)        res_q  <= res_d;
		if (advance_rpush) pend_q <= res_q;
		if (push_en)       out_q  <= push_data;
	end

	// Slot and ring memories with registered reads.
	always_ff @(posedge clk) begin
		if (conn_we) conn_mem[head.slot_idx] <= head.conn;
		conn_rd_q <= conn_mem[conn_raddr];
	end

	always_ff @(posedge clk) begin
		if (time_we) time_mem[idx_q] <= cur_q.now;
		time_rd_q <= time_mem[scan_q[5:0]];
	end

	always_ff @(posedge clk) begin
		if (ring_we) tag_mem[enq_cell] <= cur_q.req;
		tag_rd_q <= tag_mem[tag_raddr];
	end

	always_ff @(posedge clk) begin
		if (cxl_we) cxl_mem[cxl_waddr] <= cxl_wdata;
		cxl_rd_q <= cxl_mem[deq_cell];
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

// ===== bench/resource_pool_with_waiter_fifo_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resource pool result checker
// Follows the pool state through every accepted request and compares each
// result transfer with the oldest predicted result.
// ----------------------------------------------------------------------------
`default_nettype none

module resource_pool_with_waiter_fifo_checker import rpw_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_ready,
	input  wire in_item_t  in_item,
	input  wire logic      out_valid,
	input  wire logic      out_ready,
	input  wire out_item_t out_item,
	input  wire logic      cfg_write,
	input  wire logic      cfg_index,
	input  wire logic [31:0] cfg_data,
	output int             failures,
	output int             pending
);

	localparam int RING = DEF_QUEUE_DEPTH;

	logic [6:0]  pool_cfg;
	logic [15:0] stale_cfg;
	logic        registered [SLOT_COUNT];
	logic        idle_flag [SLOT_COUNT];
	logic [1:0]  condition [SLOT_COUNT];
	logic [15:0] connection [SLOT_COUNT];
	logic [15:0] holder [SLOT_COUNT];
	logic [31:0] grant_time [SLOT_COUNT];
	logic [15:0] waiter_tag [RING];
	logic        waiter_cancelled [RING];
	logic [31:0] enq_count;
	logic [31:0] deq_count;
	out_item_t   expected_results [$];

	function automatic int unsigned active_slots();
		int unsigned p;
		p = pool_cfg;
		if (p == 0) p = 1;
		if (p > SLOT_COUNT) p = SLOT_COUNT;
		return p;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		failures++;
	endtask

	// Hands the slot to the oldest live waiter, or marks it idle.
	task automatic hand_on_slot(input int idx, input logic [31:0] now);
		logic [7:0] ring_pos;
		while (deq_count != enq_count) begin
			ring_pos = deq_count[7:0];
			deq_count++;
			if (!waiter_cancelled[ring_pos]) begin
				holder[idx] = waiter_tag[ring_pos];
				grant_time[idx] = now;
				condition[idx] = COND_TAKEN;
				idle_flag[idx] = 1'b0;
				expected_results.push_back(mk_result(OUT_WAITER, holder[idx],
					connection[idx], 7'(idx + 1), '0, 1'b0));
				return;
			end
		end
		condition[idx] = COND_IDLE;
		idle_flag[idx] = 1'b1;
		expected_results.push_back(mk_result(OUT_IDLED, '0, '0, 7'(idx + 1), '0, 1'b0));
	endtask

	task automatic predict_checkout(input in_item_t it);
		int unsigned psize, sched, pshard, pbit, shard, idx;
		int found;
		logic [31:0] ofs;
		logic [7:0] ring_pos;
		psize = active_slots();
		ofs = 32'(it.scheduler_number) - 32'd1;
		sched = ofs % psize;
		pshard = sched % SHARD_COUNT;
		pbit = sched / SHARD_COUNT;
		for (int s = 0; s < SHARD_COUNT; s++) begin
			shard = (pshard + s) % SHARD_COUNT;
			found = -1;
			for (int b = 0; b < SHARD_BITS; b++) begin
				idx = b * SHARD_COUNT + shard;
				if (idx >= psize || !registered[idx] || !idle_flag[idx]) continue;
				if (s == 0 && b < pbit) begin
					if (found < 0) found = b;
					continue;
				end
				found = b;
				break;
			end
			if (found >= 0) begin
				idx = found * SHARD_COUNT + shard;
				idle_flag[idx] = 1'b0;
				condition[idx] = COND_TAKEN;
				holder[idx] = it.requester_tag;
				grant_time[idx] = it.now_ms;
				expected_results.push_back(mk_result(OUT_GRANTED, it.requester_tag,
					connection[idx], 7'(idx + 1), '0, 1'b0));
				return;
			end
		end
		if (enq_count - deq_count >= RING) begin
			expected_results.push_back(mk_result(OUT_FULL, '0, '0, '0, '0, 1'b0));
			return;
		end
		ring_pos = enq_count[7:0];
		waiter_tag[ring_pos] = it.requester_tag;
		waiter_cancelled[ring_pos] = 1'b0;
		expected_results.push_back(mk_result(OUT_QUEUED, '0, '0, '0, enq_count, 1'b0));
		enq_count++;
	endtask

	task automatic predict_request(input in_item_t it);
		int unsigned psize, found_count;
		int idx;
		out_item_t tail;
		psize = active_slots();
		found_count = 1;
		case (it.operation)
			OP_REGISTER, OP_CHECKIN: begin
				idx = int'(it.slot_number) - 1;
				if (it.slot_number == 0 || it.slot_number > psize)
					expected_results.push_back(mk_result(OUT_DONE, '0, '0, '0, '0, 1'b0));
				else if (it.operation == OP_REGISTER) begin
					connection[idx] = it.connection_tag;
					registered[idx] = 1'b1;
					hand_on_slot(idx, it.now_ms);
				end else if (!registered[idx])
					expected_results.push_back(mk_result(OUT_DONE, '0, '0, '0, '0, 1'b0));
				else
					hand_on_slot(idx, it.now_ms);
			end
			OP_CHECKOUT: predict_checkout(it);
			OP_CANCEL: begin
				if (it.ticket - deq_count < enq_count - deq_count)
					if (waiter_tag[it.ticket[7:0]] == it.requester_tag)
						waiter_cancelled[it.ticket[7:0]] = 1'b1;
				expected_results.push_back(mk_result(OUT_DONE, '0, '0, '0, '0, 1'b0));
			end
			OP_RECLAIM: begin
				found_count = 0;
				for (int i = 0; i < psize; i++)
					if (condition[i] == COND_TAKEN &&
							(it.now_ms - grant_time[i]) > 32'(stale_cfg)) begin
						hand_on_slot(i, it.now_ms);
						found_count++;
					end
				if (found_count == 0)
					expected_results.push_back(mk_result(OUT_DONE, '0, '0, '0, '0, 1'b0));
			end
			default: expected_results.push_back(mk_result(OUT_DONE, '0, '0, '0, '0, 1'b0));
		endcase
		// The final result of every request carries last.
		tail = expected_results.pop_back();
		tail.last = 1'b1;
		expected_results.push_back(tail);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			pool_cfg = POOL_RESET;
			stale_cfg = STALE_RESET;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				registered[i] = 1'b0;
				idle_flag[i] = 1'b0;
				condition[i] = COND_UNREG;
			end
			enq_count = '0;
			deq_count = '0;
			expected_results.delete();
			failures = 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_POOL_SLOTS) pool_cfg = cfg_data[6:0];
				else stale_cfg = cfg_data[15:0];
			end
			if (in_valid && in_ready) predict_request(in_item);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0)
					report_mismatch("result transfer with none expected");
				else begin
					want = expected_results.pop_front();
					if (out_item.outcome !== want.outcome)
						report_mismatch($sformatf("outcome %0d, want %0d",
							out_item.outcome, want.outcome));
					if (out_item.granted_to !== want.granted_to)
						report_mismatch($sformatf("granted_to %h, want %h",
							out_item.granted_to, want.granted_to));
					if (out_item.granted_connection !== want.granted_connection)
						report_mismatch($sformatf("granted_connection %h, want %h",
							out_item.granted_connection, want.granted_connection));
					if (out_item.granted_slot !== want.granted_slot)
						report_mismatch($sformatf("granted_slot %0d, want %0d",
							out_item.granted_slot, want.granted_slot));
					if (out_item.queue_ticket !== want.queue_ticket)
						report_mismatch($sformatf("queue_ticket %0d, want %0d",
							out_item.queue_ticket, want.queue_ticket));
					if (out_item.last !== want.last)
						report_mismatch($sformatf("last %b, want %b",
							out_item.last, want.last));
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

`default_nettype wire

// ===== bench/resource_pool_with_waiter_fifo_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resource pool testbench
// Drives register, checkout, checkin, cancel and reclaim traffic through
// several pool sizes and stale limits, with random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module resource_pool_with_waiter_fifo_test import rpw_pkg::*;;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_ready;
	in_item_t    in_item;
	logic        out_valid, out_ready;
	out_item_t   out_item;
	int          failures, pending;
	int          quiet_cycles;
	logic        calm;          // no idling on either side in the final part
	logic [31:0] clock_ms;      // advancing time base for requests
	logic [31:0] tickets [$];   // tickets seen on queued results, for cancels

	// The checker sees a configuration write at the access edge.
	wire cfg_write = psel && penable && pwrite && pready;

	resource_pool_with_waiter_fifo u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	resource_pool_with_waiter_fifo_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_write(cfg_write), .cfg_index(paddr[2]), .cfg_data(pwdata),
		.failures(failures), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The receiver stalls in random bursts, except near the end.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_ready <= 1'b1;
			end else
				out_ready <= 1'b1;
		end
	end

	// Record queued tickets so that cancels can name live waiters.
	always @(posedge clk)
		if (out_valid && out_ready && out_item.outcome == OUT_QUEUED) begin
			tickets.push_back(out_item.queue_ticket);
			if (tickets.size() > 32) void'(tickets.pop_front());
		end

	// A run with nothing accepted for too long is a hang.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_register(input logic index, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits until every predicted result has arrived, then lets the block
	// settle before any register changes. The first edge lets the checker
	// count the request accepted last.
	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// Presents one request and holds it until the block accepts it. The
	// sender may first pause for a random burst.
	task automatic send_request(input in_item_t it);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic in_item_t make_request(input logic [2:0] op, input int pool);
		in_item_t it;
		it.operation = op;
		it.slot_number = 7'($urandom_range(1, pool));
		if ($urandom_range(0, 15) == 0) it.slot_number = 7'($urandom);
		it.connection_tag = 16'($urandom);
		it.requester_tag = 16'($urandom_range(0, 7));
		if ($urandom_range(0, 3) == 0) it.requester_tag = 16'($urandom);
		it.scheduler_number = 11'($urandom_range(1, 1024));
		if ($urandom_range(0, 15) == 0) it.scheduler_number = 11'($urandom);
		it.ticket = $urandom;
		if (tickets.size() != 0 && $urandom_range(0, 3) != 0)
			it.ticket = tickets[$urandom_range(0, tickets.size() - 1)];
		it.now_ms = clock_ms;
		if ($urandom_range(0, 7) == 0) it.now_ms = $urandom;
		return it;
	endfunction

	// Random phase: mostly checkouts and checkins against registered slots,
	// with cancels, reclaims and the odd unknown operation mixed in.
	task automatic random_phase(input int count, input int pool);
		in_item_t it;
		int pick;
		logic [2:0] op;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) op = OP_REGISTER;
			else if (pick < 45) op = OP_CHECKOUT;
			else if (pick < 72) op = OP_CHECKIN;
			else if (pick < 84) op = OP_CANCEL;
			else if (pick < 96) op = OP_RECLAIM;
			else op = 3'($urandom_range(5, 7));
			clock_ms = clock_ms + $urandom_range(0, 400);
			it = make_request(op, pool);
			send_request(it);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		in_item_t it;
		arst_n = 1'b0;
		calm = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		clock_ms = 32'hFFFF_F000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset configuration: unregistered checkin,
		// out-of-range slots, an empty reclaim and two checkouts that queue.
		it = '0;
		it.operation = OP_CHECKIN;  it.slot_number = 7'd5;       send_request(it);
		it.operation = OP_REGISTER; it.slot_number = 7'd0;       send_request(it);
		it.slot_number = 7'd65;                                  send_request(it);
		it.slot_number = 7'd127;                                 send_request(it);
		it.operation = OP_RECLAIM;  it.now_ms = 32'hFFFF_FFFF;   send_request(it);
		it.operation = OP_CHECKOUT; it.requester_tag = 16'hFFFF;
		it.scheduler_number = 11'd0;                             send_request(it);
		it.scheduler_number = 11'h7FF;                           send_request(it);
		// A cancel with the wrong tag leaves the first waiter live, the right
		// tag cancels the second, so register skips it.
		it.operation = OP_CANCEL;   it.ticket = 32'd0; it.requester_tag = 16'd1;
		send_request(it);
		it.ticket = 32'd1; it.requester_tag = 16'hFFFF;          send_request(it);
		it.ticket = 32'hFFFF_FFFF;                               send_request(it);
		it.operation = OP_REGISTER; it.slot_number = 7'd64;
		it.connection_tag = 16'hFFFF; it.now_ms = 32'd0;         send_request(it);
		it.slot_number = 7'd1; it.connection_tag = 16'h0000;     send_request(it);
		it.slot_number = 7'd17; it.connection_tag = 16'h1234;    send_request(it);
		it.operation = OP_CHECKOUT; it.requester_tag = 16'h0000;
		it.scheduler_number = 11'd1024;                          send_request(it);
		it.scheduler_number = 11'd1;                             send_request(it);
		it.operation = OP_CHECKIN; it.slot_number = 7'd17;       send_request(it);
		it.operation = OP_RECLAIM; it.now_ms = 32'd5000;         send_request(it);
		it.operation = 3'd7;                                     send_request(it);
		in_valid <= 1'b0;
		drain();

		// Register the whole pool, then randomize at the default size.
		for (int s = 1; s <= SLOT_COUNT; s++) begin
			it = make_request(OP_REGISTER, SLOT_COUNT);
			it.slot_number = 7'(s);
			send_request(it);
		end
		in_valid <= 1'b0;
		random_phase(80, SLOT_COUNT);
		drain();

		// Smallest pool and zero stale limit: nearly everything queues.
		write_register(REG_POOL_SLOTS, 32'd1);
		write_register(REG_STALE, 32'd0);
		random_phase(70, 2);
		drain();

		// Pool size of zero acts as one; largest stale limit.
		write_register(REG_POOL_SLOTS, 32'd0);
		write_register(REG_STALE, 32'd65535);
		random_phase(50, 2);
		drain();

		// Middle sizes, and a size above the slot count.
		write_register(REG_POOL_SLOTS, 32'd20);
		write_register(REG_STALE, 32'($urandom_range(0, 2000)));
		random_phase(80, 20);
		drain();
		write_register(REG_POOL_SLOTS, 32'd127);
		write_register(REG_STALE, 32'd500);
		random_phase(60, SLOT_COUNT);

		// The last stretch runs with both sides always ready.
		calm = 1'b1;
		random_phase(60, SLOT_COUNT);

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
